@@ rtl/cvsd_pkg.sv @@
// ----------------------------------------------------------------------------
// cvsd_pkg
// Shared widths, constants, register indexes and types of the CAN vehicle
// status decoder.
// ----------------------------------------------------------------------------
package cvsd_pkg;

	localparam int unsigned IdW      = 29;
	localparam int unsigned LenW     = 4;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned WordW    = 16;
	localparam int unsigned SeqW     = 32;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 29;

	// Minimum payload bytes for each frame kind
	localparam logic [LenW-1:0] PtMinLen = LenW'(6);
	localparam logic [LenW-1:0] ChMinLen = LenW'(2);

	// Identifier reset values
	localparam logic [IdW-1:0] PtIdReset = IdW'(256);
	localparam logic [IdW-1:0] ChIdReset = IdW'(257);

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_POWERTRAIN_ID = 2'd0,
		REG_CHASSIS_ID    = 2'd1,
		REG_REQUIRE_BOTH  = 2'd2
	} cfg_reg_t;

	// One received CAN frame
	typedef struct packed {
		logic             is_remote;
		logic [IdW-1:0]   frame_id;
		logic [LenW-1:0]  data_length;
		logic [ByteW-1:0] byte0;
		logic [ByteW-1:0] byte1;
		logic [ByteW-1:0] byte2;
		logic [ByteW-1:0] byte3;
		logic [ByteW-1:0] byte4;
		logic [ByteW-1:0] byte5;
	} frame_t;

	// One emitted snapshot
	typedef struct packed {
		logic [WordW-1:0] speed_centi_kph;
		logic [WordW-1:0] engine_rpm;
		logic [ByteW-1:0] gear;
		logic [ByteW-1:0] status_bits;
		logic [WordW-1:0] steering_raw;
		logic [SeqW-1:0]  sequence_number;
	} snap_t;

	// Configuration seen by the classifier
	typedef struct packed {
		logic [IdW-1:0] powertrain_id;
		logic [IdW-1:0] chassis_id;
		logic           require_both;
	} cfg_t;

	// Seen flags held across frames
	typedef struct packed {
		logic powertrain;
		logic chassis;
	} seen_t;

	// Decision for one frame
	typedef struct packed {
		logic pt_hit;
		logic ch_hit;
		logic emit;
	} decision_t;

endpackage

@@ rtl/cvsd_if.sv @@
// ----------------------------------------------------------------------------
// cvsd interfaces
// Valid/ready channels for frames, snapshots and configuration writes.
// ----------------------------------------------------------------------------
interface cvsd_frame_if;
	logic                        valid;
	logic                        ready;
	logic                        is_remote;
	logic [cvsd_pkg::IdW-1:0]    frame_id;
	logic [cvsd_pkg::LenW-1:0]   data_length;
	logic [cvsd_pkg::ByteW-1:0]  byte0;
	logic [cvsd_pkg::ByteW-1:0]  byte1;
	logic [cvsd_pkg::ByteW-1:0]  byte2;
	logic [cvsd_pkg::ByteW-1:0]  byte3;
	logic [cvsd_pkg::ByteW-1:0]  byte4;
	logic [cvsd_pkg::ByteW-1:0]  byte5;

	modport source (
		output valid, is_remote, frame_id, data_length,
		output byte0, byte1, byte2, byte3, byte4, byte5,
		input  ready
	);
	modport sink (
		input  valid, is_remote, frame_id, data_length,
		input  byte0, byte1, byte2, byte3, byte4, byte5,
		output ready
	);
endinterface

interface cvsd_snap_if;
	logic                        valid;
	logic                        ready;
	logic [cvsd_pkg::WordW-1:0]  speed_centi_kph;
	logic [cvsd_pkg::WordW-1:0]  engine_rpm;
	logic [cvsd_pkg::ByteW-1:0]  gear;
	logic [cvsd_pkg::ByteW-1:0]  status_bits;
	logic [cvsd_pkg::WordW-1:0]  steering_raw;
	logic [cvsd_pkg::SeqW-1:0]   sequence_number;

	modport source (
		output valid, speed_centi_kph, engine_rpm, gear, status_bits,
		output steering_raw, sequence_number,
		input  ready
	);
	modport sink (
		input  valid, speed_centi_kph, engine_rpm, gear, status_bits,
		input  steering_raw, sequence_number,
		output ready
	);
endinterface

interface cvsd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cvsd_pkg::CfgIdxW-1:0]   index;
	logic [cvsd_pkg::CfgDataW-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/cvsd_classify.sv @@
// ----------------------------------------------------------------------------
// cvsd_classify
// Sorts one frame into powertrain, chassis or ignored, and decides whether
// it publishes a snapshot.
// ----------------------------------------------------------------------------
module cvsd_classify (
	input  cvsd_pkg::frame_t    item,
	input  cvsd_pkg::cfg_t      cfg,
	input  cvsd_pkg::seen_t     seen,
	output cvsd_pkg::decision_t decision
);

	logic pt_match;
	logic ch_match;
	logic pt_seen_next;
	logic ch_seen_next;

	// Match identifiers; the powertrain match wins when both ids are equal
	assign pt_match = (item.frame_id == cfg.powertrain_id);
	assign ch_match = !pt_match && (item.frame_id == cfg.chassis_id);

	// Drop remote and short frames
	assign decision.pt_hit = !item.is_remote && pt_match
		&& (item.data_length >= cvsd_pkg::PtMinLen);
	assign decision.ch_hit = !item.is_remote && ch_match
		&& (item.data_length >= cvsd_pkg::ChMinLen);

	// Hold back output until both kinds are seen when required
	assign pt_seen_next = seen.powertrain || decision.pt_hit;
	assign ch_seen_next = seen.chassis || decision.ch_hit;
	assign decision.emit = (decision.pt_hit || decision.ch_hit)
		&& (!cfg.require_both || (pt_seen_next && ch_seen_next));

endmodule

@@ rtl/can_vehicle_status_decoder_core.sv @@
// ----------------------------------------------------------------------------
// can_vehicle_status_decoder_core
// Pipeline: a frame is registered in the input register, then decoded into
//   the snapshot register, which offers its snapshot; while the snapshot
//   register is held by back-pressure, the frame waits in the input register.
// Throughput: one frame per cycle while the snapshot register is free or draining.
// Reset: asynchronous, active low; clears held signals, seen flags, sequence
//   counter and valids, and loads the identifier registers with 256 and 257.
// ----------------------------------------------------------------------------
module can_vehicle_status_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	cvsd_frame_if.sink     frame,
	cvsd_snap_if.source    snapshot,
	cvsd_cfg_if.sink       cfg
);

	cvsd_pkg::cfg_t      cfg_q;
	cvsd_pkg::seen_t     seen_q;
	cvsd_pkg::frame_t    in_item;
	cvsd_pkg::frame_t    item_s1;
	cvsd_pkg::decision_t decision;
	cvsd_pkg::snap_t     snap_next;
	cvsd_pkg::snap_t     snap_s2;

	logic                         valid_s1;
	logic                         valid_s2;
	logic                         advance_s1;
	logic [cvsd_pkg::WordW-1:0]   speed_q;
	logic [cvsd_pkg::WordW-1:0]   rpm_q;
	logic [cvsd_pkg::ByteW-1:0]   gear_q;
	logic [cvsd_pkg::ByteW-1:0]   status_q;
	logic [cvsd_pkg::WordW-1:0]   steering_q;
	logic [cvsd_pkg::SeqW-1:0]    seq_q;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.powertrain_id <= cvsd_pkg::PtIdReset;
			cfg_q.chassis_id    <= cvsd_pkg::ChIdReset;
			cfg_q.require_both  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cvsd_pkg::REG_POWERTRAIN_ID: cfg_q.powertrain_id <= cfg.data[cvsd_pkg::IdW-1:0];
				cvsd_pkg::REG_CHASSIS_ID:    cfg_q.chassis_id    <= cfg.data[cvsd_pkg::IdW-1:0];
				cvsd_pkg::REG_REQUIRE_BOTH:  cfg_q.require_both  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Gather the frame fields
	assign in_item = '{
		is_remote:   frame.is_remote,
		frame_id:    frame.frame_id,
		data_length: frame.data_length,
		byte0:       frame.byte0,
		byte1:       frame.byte1,
		byte2:       frame.byte2,
		byte3:       frame.byte3,
		byte4:       frame.byte4,
		byte5:       frame.byte5
	};

	// Advance stage 1 whenever the snapshot register is free or draining
	assign advance_s1  = valid_s1 && (!valid_s2 || snapshot.ready);
	assign frame.ready = !valid_s1 || advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			item_s1 <= in_item;
		end
	end

	cvsd_classify u_classify (
		.item     (item_s1),
		.cfg      (cfg_q),
		.seen     (seen_q),
		.decision (decision)
	);

	// Build the snapshot from the updated signals
	always_comb begin
		snap_next.speed_centi_kph = decision.pt_hit ? {item_s1.byte1, item_s1.byte0} : speed_q;
		snap_next.engine_rpm      = decision.pt_hit ? {item_s1.byte3, item_s1.byte2} : rpm_q;
		snap_next.gear            = decision.pt_hit ? item_s1.byte4 : gear_q;
		snap_next.status_bits     = decision.pt_hit ? item_s1.byte5 : status_q;
		snap_next.steering_raw    = decision.ch_hit ? {item_s1.byte1, item_s1.byte0} : steering_q;
		snap_next.sequence_number = seq_q;
	end

	// Update held signals, seen flags and sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= '0;
			rpm_q      <= '0;
			gear_q     <= '0;
			status_q   <= '0;
			steering_q <= '0;
			seq_q      <= '0;
			seen_q     <= '0;
		end else if (advance_s1) begin
			speed_q            <= snap_next.speed_centi_kph;
			rpm_q              <= snap_next.engine_rpm;
			gear_q             <= snap_next.gear;
			status_q           <= snap_next.status_bits;
			steering_q         <= snap_next.steering_raw;
			seen_q.powertrain  <= seen_q.powertrain || decision.pt_hit;
			seen_q.chassis     <= seen_q.chassis || decision.ch_hit;
			if (decision.emit) begin
				seq_q <= seq_q + cvsd_pkg::SeqW'(1);
			end
		end
	end

	// Snapshot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || snapshot.ready) begin
			valid_s2 <= advance_s1 && decision.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && decision.emit) begin
			snap_s2 <= snap_next;
		end
	end

	assign snapshot.valid           = valid_s2;
	assign snapshot.speed_centi_kph = snap_s2.speed_centi_kph;
	assign snapshot.engine_rpm      = snap_s2.engine_rpm;
	assign snapshot.gear            = snap_s2.gear;
	assign snapshot.status_bits     = snap_s2.status_bits;
	assign snapshot.steering_raw    = snap_s2.steering_raw;
	assign snapshot.sequence_number = snap_s2.sequence_number;

endmodule
